// ----- sv/alamouti_ml_psk8_detector_core_defines.svh -----
// ----------------------------------------------------------------------------
// alamouti ml 8-psk detector assertion macros
// shared clocked assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ALAMOUTI_ML_PSK8_DETECTOR_CORE_DEFINES_SVH
`define ALAMOUTI_ML_PSK8_DETECTOR_CORE_DEFINES_SVH

// property checked outside reset
`define AMLPSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also looks at reset itself
`define AMLPSK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/amlpsk_pkg.sv -----
// ----------------------------------------------------------------------------
// amlpsk_pkg
// widths, command codes and constellation tables of the alamouti detector
// ----------------------------------------------------------------------------
package amlpsk_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 4;
  localparam int POINTS      = 8;
  localparam int PT_BITS     = 3;
  localparam int SUM_BITS    = 24;
  localparam int SYM_BITS    = 3;
  localparam int DIST_BITS   = 24;

  localparam int ACC_BITS    = 34;
  localparam int MA_BITS     = 34;
  localparam int MB_BITS     = 23;
  localparam int PROD_BITS   = MA_BITS + MB_BITS;
  localparam int RND_SHIFT   = 14;
  localparam int RND_BITS    = PROD_BITS - RND_SHIFT;
  localparam int DIFF_BITS   = 44;
  localparam int ABS_BITS    = 22;
  localparam int RAD_BITS    = 44;
  localparam int ROOT_STEPS  = RAD_BITS / 2;
  localparam int ROOT_BITS   = ROOT_STEPS;
  localparam int COEF_BITS   = 15;

  localparam int MAC_STEPS   = 20;
  localparam int STEP_BITS   = 5;
  localparam int CNT_BITS    = 5;
  localparam int NUM_ACC     = 5;

  typedef logic [3:0] op_t;
  localparam op_t OP_IDLE      = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_MAC       = 4'd2;
  localparam op_t OP_MC_RE     = 4'd3;
  localparam op_t OP_MC_IM     = 4'd4;
  localparam op_t OP_DIFF      = 4'd5;
  localparam op_t OP_SQ_RE     = 4'd6;
  localparam op_t OP_SQ_IM     = 4'd7;
  localparam op_t OP_ROOT_INIT = 4'd8;
  localparam op_t OP_ROOT_STEP = 4'd9;
  localparam op_t OP_ACCUM     = 4'd10;
  localparam op_t OP_SCAN_INIT = 4'd11;
  localparam op_t OP_SCAN      = 4'd12;
  localparam op_t OP_EMIT      = 4'd13;

  typedef struct packed {
    op_t                  op;
    logic [STEP_BITS-1:0] step;
    logic [PT_BITS-1:0]   pt;
    logic                 sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] a_idx;
    logic [2:0] b_idx;
    logic       neg;
  } mac_sel_t;

  // sample order: h1r h1i h2r h2i y0r y0i y1r y1i
  // four products per target: m, r1r, r1i, r2r, r2i
  function automatic mac_sel_t mac_sel(input logic [STEP_BITS-1:0] step);
    mac_sel_t s;
    s = '{a_idx: 3'd0, b_idx: 3'd0, neg: 1'b0};
    case (step)
      5'd0:  s = '{3'd0, 3'd0, 1'b0};
      5'd1:  s = '{3'd1, 3'd1, 1'b0};
      5'd2:  s = '{3'd2, 3'd2, 1'b0};
      5'd3:  s = '{3'd3, 3'd3, 1'b0};
      5'd4:  s = '{3'd0, 3'd4, 1'b0};
      5'd5:  s = '{3'd1, 3'd5, 1'b0};
      5'd6:  s = '{3'd2, 3'd6, 1'b0};
      5'd7:  s = '{3'd3, 3'd7, 1'b0};
      5'd8:  s = '{3'd0, 3'd5, 1'b0};
      5'd9:  s = '{3'd1, 3'd4, 1'b1};
      5'd10: s = '{3'd3, 3'd6, 1'b0};
      5'd11: s = '{3'd2, 3'd7, 1'b1};
      5'd12: s = '{3'd0, 3'd6, 1'b0};
      5'd13: s = '{3'd1, 3'd7, 1'b0};
      5'd14: s = '{3'd2, 3'd4, 1'b1};
      5'd15: s = '{3'd3, 3'd5, 1'b1};
      5'd16: s = '{3'd1, 3'd6, 1'b0};
      5'd17: s = '{3'd0, 3'd7, 1'b1};
      5'd18: s = '{3'd2, 3'd5, 1'b1};
      5'd19: s = '{3'd3, 3'd4, 1'b0};
      default: s = '{3'd0, 3'd0, 1'b0};
    endcase
    return s;
  endfunction

  // sixteenth-circle points scaled by 1/sqrt2, q1.14
  function automatic logic signed [COEF_BITS-1:0] psk_re(input logic [3:0] k);
    logic signed [COEF_BITS-1:0] v;
    v = '0;
    case (k)
      4'd0:  v = 15'sd11585;
      4'd1:  v = 15'sd10703;
      4'd2:  v = 15'sd8192;
      4'd3:  v = 15'sd4433;
      4'd4:  v = 15'sd0;
      4'd5:  v = -15'sd4433;
      4'd6:  v = -15'sd8192;
      4'd7:  v = -15'sd10703;
      4'd8:  v = -15'sd11585;
      4'd9:  v = -15'sd10703;
      4'd10: v = -15'sd8192;
      4'd11: v = -15'sd4433;
      4'd12: v = 15'sd0;
      4'd13: v = 15'sd4433;
      4'd14: v = 15'sd8192;
      default: v = 15'sd10703;
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_BITS-1:0] psk_im(input logic [3:0] k);
    return psk_re(k - 4'd4);
  endfunction

endpackage

// ----- sv/amlpsk_dp.sv -----
// ----------------------------------------------------------------------------
// amlpsk_dp
// datapath: shared multiplier, combiner accumulators, bitwise root, sum tables
// ----------------------------------------------------------------------------
module amlpsk_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  amlpsk_pkg::cmd_t                     cmd,
  input  logic [8*amlpsk_pkg::SAMPLE_BITS-1:0] in_samples,
  output logic [amlpsk_pkg::SYM_BITS-1:0]      first_symbol,
  output logic [amlpsk_pkg::SYM_BITS-1:0]      second_symbol,
  output logic [amlpsk_pkg::DIST_BITS-1:0]     first_distance,
  output logic [amlpsk_pkg::DIST_BITS-1:0]     second_distance
);
  import amlpsk_pkg::*;

  logic signed [SAMPLE_BITS-1:0] samp_r [8];
  logic signed [ACC_BITS-1:0]    acc_r  [NUM_ACC];
  logic signed [PROD_BITS-1:0]   prod_r;
  logic [STEP_BITS-1:0]          pstep_r;
  logic                          pend_r;
  logic signed [RND_BITS-1:0]    pr_r;
  logic [ABS_BITS-1:0]           ur_r, ui_r;
  logic [RAD_BITS-1:0]           sq_r, rad_r, res_r, bit_r;
  logic [SUM_BITS-1:0]           f_sum_r [POINTS];
  logic [SUM_BITS-1:0]           s_sum_r [POINTS];
  logic [SUM_BITS-1:0]           best1_r, best2_r;
  logic [PT_BITS-1:0]            bidx1_r, bidx2_r;
  logic [SYM_BITS-1:0]           fsym_r, ssym_r;
  logic [DIST_BITS-1:0]          fdist_r, sdist_r;

  mac_sel_t                      msel, psel;
  logic signed [MA_BITS-1:0]     ma;
  logic signed [MB_BITS-1:0]     mb;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   rnd_sum;
  logic signed [RND_BITS-1:0]    rnd_w;
  logic [3:0]                    kidx;
  logic signed [COEF_BITS-1:0]   c_re, c_im;
  logic signed [ACC_BITS-1:0]    ar, ai;
  logic signed [DIFF_BITS-1:0]   dre, dim, sre, sim;
  logic [RAD_BITS-1:0]           trial;
  logic [SUM_BITS:0]             f_add, s_add;
  logic [SUM_BITS-1:0]           f_sat, s_sat;
  logic signed [ACC_BITS-1:0]    pterm;

  assign msel = mac_sel(cmd.step);
  assign psel = mac_sel(pstep_r);
  // point p sits at sixteenth k = p * 16 / POINTS
  assign kidx = 4'((32'(cmd.pt) * 16) / POINTS);
  assign c_re = psk_re(kidx);
  assign c_im = cmd.sel ? -psk_im(kidx) : psk_im(kidx);
  assign ar   = cmd.sel ? acc_r[3] : acc_r[1];
  assign ai   = cmd.sel ? acc_r[4] : acc_r[2];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MAC: begin
        ma = MA_BITS'(samp_r[msel.a_idx]);
        mb = MB_BITS'(samp_r[msel.b_idx]);
      end
      OP_MC_RE: begin
        ma = MA_BITS'(acc_r[0]);
        mb = MB_BITS'(c_re);
      end
      OP_MC_IM: begin
        ma = MA_BITS'(acc_r[0]);
        mb = MB_BITS'(c_im);
      end
      OP_SQ_RE: begin
        ma = MA_BITS'($signed({1'b0, ur_r}));
        mb = MB_BITS'($signed({1'b0, ur_r}));
      end
      OP_SQ_IM: begin
        ma = MA_BITS'($signed({1'b0, ui_r}));
        mb = MB_BITS'($signed({1'b0, ui_r}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // round half up then drop 14 fraction bits
  assign rnd_sum = prod_r + PROD_BITS'(1 << (RND_SHIFT - 1));
  assign rnd_w   = rnd_sum[PROD_BITS-1:RND_SHIFT];

  assign dre = DIFF_BITS'(ar) - DIFF_BITS'(pr_r);
  assign dim = DIFF_BITS'(ai) - DIFF_BITS'(rnd_w);
  assign sre = dre >>> FRAC_BITS;
  assign sim = dim >>> FRAC_BITS;

  assign trial = res_r + bit_r;
  assign pterm = ACC_BITS'(prod_r);

  assign f_add = {1'b0, f_sum_r[cmd.pt]} + (SUM_BITS + 1)'(res_r[ROOT_BITS-1:0]);
  assign s_add = {1'b0, s_sum_r[cmd.pt]} + (SUM_BITS + 1)'(res_r[ROOT_BITS-1:0]);
  assign f_sat = f_add[SUM_BITS] ? '1 : f_add[SUM_BITS-1:0];
  assign s_sat = s_add[SUM_BITS] ? '1 : s_add[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    pend_r  <= (cmd.op == OP_MAC);
    pstep_r <= cmd.step;
    if (cmd.op == OP_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        samp_r[i] <= in_samples[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (cmd.op == OP_MAC || cmd.op == OP_MC_RE || cmd.op == OP_MC_IM ||
        cmd.op == OP_SQ_RE || cmd.op == OP_SQ_IM) begin
      prod_r <= prod;
    end
    // product of the previous step lands in its accumulator
    if (cmd.op == OP_LOAD) begin
      for (int i = 0; i < NUM_ACC; i++) begin
        acc_r[i] <= '0;
      end
    end else if (pend_r) begin
      acc_r[pstep_r[4:2]] <= psel.neg ? acc_r[pstep_r[4:2]] - pterm
                                      : acc_r[pstep_r[4:2]] + pterm;
    end
    if (cmd.op == OP_MC_IM) begin
      pr_r <= rnd_w;
    end
    if (cmd.op == OP_DIFF) begin
      ur_r <= sre[DIFF_BITS-1] ? ABS_BITS'(-sre) : ABS_BITS'(sre);
      ui_r <= sim[DIFF_BITS-1] ? ABS_BITS'(-sim) : ABS_BITS'(sim);
    end
    if (cmd.op == OP_SQ_IM) begin
      sq_r <= prod_r[RAD_BITS-1:0];
    end
    if (cmd.op == OP_ROOT_INIT) begin
      rad_r <= sq_r + prod_r[RAD_BITS-1:0];
      res_r <= '0;
      bit_r <= RAD_BITS'(1) << (RAD_BITS - 2);
    end else if (cmd.op == OP_ROOT_STEP) begin
      if (rad_r >= trial) begin
        rad_r <= rad_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.op == OP_SCAN_INIT) begin
      best1_r <= f_sum_r[0];
      best2_r <= s_sum_r[0];
      bidx1_r <= '0;
      bidx2_r <= '0;
    end else if (cmd.op == OP_SCAN) begin
      if (f_sum_r[cmd.pt] < best1_r) begin
        best1_r <= f_sum_r[cmd.pt];
        bidx1_r <= cmd.pt;
      end
      if (s_sum_r[cmd.pt] < best2_r) begin
        best2_r <= s_sum_r[cmd.pt];
        bidx2_r <= cmd.pt;
      end
    end
    if (cmd.op == OP_EMIT) begin
      fsym_r  <= SYM_BITS'(bidx1_r);
      ssym_r  <= SYM_BITS'(bidx2_r);
      fdist_r <= DIST_BITS'(best1_r);
      sdist_r <= DIST_BITS'(best2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == OP_EMIT) begin
      for (int i = 0; i < POINTS; i++) begin
        f_sum_r[i] <= '0;
        s_sum_r[i] <= '0;
      end
    end else if (cmd.op == OP_ACCUM) begin
      if (cmd.sel) begin
        s_sum_r[cmd.pt] <= s_sat;
      end else begin
        f_sum_r[cmd.pt] <= f_sat;
      end
    end
  end

  assign first_symbol    = fsym_r;
  assign second_symbol   = ssym_r;
  assign first_distance  = fdist_r;
  assign second_distance = sdist_r;

endmodule

// ----- sv/amlpsk_ctrl.sv -----
// ----------------------------------------------------------------------------
// amlpsk_ctrl
// sequencer: combiner products, per-point distance steps, argmin scan, output
// ----------------------------------------------------------------------------
module amlpsk_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output amlpsk_pkg::cmd_t cmd
);
  import amlpsk_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MAC       = 4'd1;
  localparam logic [3:0] S_MC_RE     = 4'd2;
  localparam logic [3:0] S_MC_IM     = 4'd3;
  localparam logic [3:0] S_DIFF      = 4'd4;
  localparam logic [3:0] S_SQ_RE     = 4'd5;
  localparam logic [3:0] S_SQ_IM     = 4'd6;
  localparam logic [3:0] S_ROOT_INIT = 4'd7;
  localparam logic [3:0] S_ROOT      = 4'd8;
  localparam logic [3:0] S_ACCUM     = 4'd9;
  localparam logic [3:0] S_SCAN_INIT = 4'd10;
  localparam logic [3:0] S_SCAN      = 4'd11;
  localparam logic [3:0] S_EMIT      = 4'd12;

  logic [3:0]           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [PT_BITS-1:0]   pt_r, pt_nxt;
  logic                 sel_r, sel_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic                 slot_free;
  op_t                  op;

  assign slot_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    pt_nxt     = pt_r;
    sel_nxt    = sel_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r && !out_tready;
    op         = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          last_nxt  = in_tlast;
          step_nxt  = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        op = OP_MAC;
        if (step_r == STEP_BITS'(MAC_STEPS - 1)) begin
          pt_nxt    = '0;
          sel_nxt   = 1'b0;
          state_nxt = S_MC_RE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MC_RE: begin
        op        = OP_MC_RE;
        state_nxt = S_MC_IM;
      end
      S_MC_IM: begin
        op        = OP_MC_IM;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        op        = OP_DIFF;
        state_nxt = S_SQ_RE;
      end
      S_SQ_RE: begin
        op        = OP_SQ_RE;
        state_nxt = S_SQ_IM;
      end
      S_SQ_IM: begin
        op        = OP_SQ_IM;
        state_nxt = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        op        = OP_ROOT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        op = OP_ROOT_STEP;
        if (cnt_r == CNT_BITS'(ROOT_STEPS - 1)) begin
          state_nxt = S_ACCUM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACCUM: begin
        op = OP_ACCUM;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_MC_RE;
        end else if (pt_r == PT_BITS'(POINTS - 1)) begin
          state_nxt = last_r ? S_SCAN_INIT : S_IDLE;
        end else begin
          pt_nxt    = pt_r + 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = S_MC_RE;
        end
      end
      S_SCAN_INIT: begin
        op        = OP_SCAN_INIT;
        pt_nxt    = PT_BITS'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (pt_r == PT_BITS'(POINTS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          pt_nxt = pt_r + 1'b1;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the word
        if (slot_free) begin
          op         = OP_EMIT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      step_r   <= '0;
      pt_r     <= '0;
      sel_r    <= 1'b0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      step_r   <= step_nxt;
      pt_r     <= pt_nxt;
      sel_r    <= sel_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
    end
  end

  assign cmd        = '{op: op, step: step_r, pt: pt_r, sel: sel_r};
  assign out_tvalid = ovalid_r;

endmodule

// ----- sv/alamouti_ml_psk8_detector_core.sv -----
// ----------------------------------------------------------------------------
// alamouti_ml_psk8_detector_core
// two-transmit alamouti combiner with exhaustive 8-psk ml search per antenna
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser / tlast
//  in_      in   8 x 16b gains and samples               tlast = last antenna
//  out_     out  symbols and winning distances (56b)     none
//
//  one word at a time: accepted in idle, 20 combiner products, then per point
//  and symbol the products, difference, squares, root init, bitwise root and
//  one sum update; a last-antenna word adds the argmin scan and output load
//  the shared multiplier and the one-bit-per-cycle root unit set this sequence
//  reset clears the control and the distance sums
//  a stalled output holds the next last-antenna word in its output step
module alamouti_ml_psk8_detector_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // gain_first_re, gain_first_im, gain_second_re, gain_second_im,
  // rx_even_re, rx_even_im, rx_odd_re, rx_odd_im (16b each)
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // first_symbol[2:0], second_symbol[5:3], first_distance[29:6],
  // second_distance[53:30], zero pad[55:54]
  output logic [55:0]  out_tdata
);
  import amlpsk_pkg::*;

  cmd_t                 cmd;
  logic [SYM_BITS-1:0]  first_symbol, second_symbol;
  logic [DIST_BITS-1:0] first_distance, second_distance;

  amlpsk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  amlpsk_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_samples      (in_tdata),
    .first_symbol    (first_symbol),
    .second_symbol   (second_symbol),
    .first_distance  (first_distance),
    .second_distance (second_distance)
  );

  assign out_tdata = {2'b00, second_distance, first_distance, second_symbol, first_symbol};

endmodule

// ----- sv/amlpsk_chk.sv -----
// ----------------------------------------------------------------------------
// amlpsk_chk
// port-level checks of the detector core, bound to the top level
// ----------------------------------------------------------------------------
`include "alamouti_ml_psk8_detector_core_defines.svh"

module amlpsk_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // stalled result word holds
  `AMLPSK_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out word changed under stall")

  // one word at a time: busy right after accepting
  `AMLPSK_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted a second word back to back")

  // a non-last word never produces a result soon after
  `AMLPSK_ASSERT(a_no_early_result, in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid), "result without last antenna")

  // reset empties the output register
  `AMLPSK_ASSERT_RST(a_reset_clear, !rst_n |=> !out_tvalid, "out valid after reset")

  // padding bits stay zero
  `AMLPSK_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[55:54] == 2'b00, "out padding not zero")

endmodule

bind alamouti_ml_psk8_detector_core amlpsk_chk u_amlpsk_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/alamouti_ml_psk8_detector_core_tb.sv -----
// ----------------------------------------------------------------------------
// alamouti ml 8-psk detector testbench
// drives antenna words with random idling and output stalls, predicts the
// symbol decisions and winning distances, and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alamouti_ml_psk8_detector_core_tb;
  import amlpsk_pkg::*;

  typedef struct {
    logic [2:0]  sym_a;
    logic [2:0]  sym_b;
    logic [23:0] dist_a;
    logic [23:0] dist_b;
  } decision_t;

  class decision_scoreboard;
    longint unsigned sums_a[POINTS];
    longint unsigned sums_b[POINTS];
    decision_t pending[$];
    int errors;

    function new();
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      for (int p = 0; p < POINTS; p++) begin
        sums_a[p] = 0;
        sums_b[p] = 0;
      end
    endfunction

    function longint signed sx(logic [15:0] v);
      return longint'(signed'(v));
    endfunction

    function longint signed fshr(longint signed x, int n);
      return x >>> n;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned point_dist(longint signed ar, longint signed ai,
                                         longint signed m, longint signed cr,
                                         longint signed ci);
      longint signed pr, pi, dr, di;
      pr = fshr(m * cr + 8192, 14);
      pi = fshr(m * ci + 8192, 14);
      dr = fshr(ar - pr, FRAC_BITS);
      di = fshr(ai - pi, FRAC_BITS);
      if (dr < 0) dr = -dr;
      if (di < 0) di = -di;
      return root_floor(longint'(dr * dr + di * di));
    endfunction

    function longint unsigned sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'hFFFFFF) ? 64'hFFFFFF : s;
    endfunction

    // sixteenth-circle coordinate, index taken mod 16
    function int psk_coord(int k);
      int t[16] = '{11585, 10703, 8192, 4433, 0, -4433, -8192, -10703,
                    -11585, -10703, -8192, -4433, 0, 4433, 8192, 10703};
      return t[k % 16];
    endfunction

    // note one accepted antenna word
    function void note_word(logic [127:0] d, logic last);
      longint signed h1r, h1i, h2r, h2i, y0r, y0i, y1r, y1i, m, r1r, r1i, r2r, r2i;
      longint signed cr, ci;
      int ba, bb;
      decision_t e;
      h1r = sx(d[15:0]);    h1i = sx(d[31:16]);
      h2r = sx(d[47:32]);   h2i = sx(d[63:48]);
      y0r = sx(d[79:64]);   y0i = sx(d[95:80]);
      y1r = sx(d[111:96]);  y1i = sx(d[127:112]);
      m = h1r * h1r + h1i * h1i + h2r * h2r + h2i * h2i;
      r1r = (h1r * y0r + h1i * y0i) + (h2r * y1r + h2i * y1i);
      r1i = (h1r * y0i - h1i * y0r) + (h2i * y1r - h2r * y1i);
      r2r = (h1r * y1r + h1i * y1i) - (h2r * y0r + h2i * y0i);
      r2i = (h1i * y1r - h1r * y1i) - (h2r * y0i - h2i * y0r);
      for (int p = 0; p < POINTS; p++) begin
        cr = longint'(psk_coord(p * 2));
        ci = longint'(psk_coord(p * 2 + 12));
        sums_a[p] = sat(sums_a[p], point_dist(r1r, r1i, m, cr, ci));
        sums_b[p] = sat(sums_b[p], point_dist(r2r, r2i, m, cr, -ci));
      end
      if (!last) return;
      ba = 0;
      bb = 0;
      for (int p = 1; p < POINTS; p++) begin
        if (sums_a[p] < sums_a[ba]) ba = p;
        if (sums_b[p] < sums_b[bb]) bb = p;
      end
      e.sym_a = ba[2:0];
      e.sym_b = bb[2:0];
      e.dist_a = sums_a[ba][23:0];
      e.dist_b = sums_b[bb][23:0];
      pending.push_back(e);
      clear_sums();
    endfunction

    function void check_word(logic [55:0] w);
      decision_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w[2:0] !== e.sym_a) begin
        $error("first_symbol exp %0d got %0d", e.sym_a, w[2:0]); errors++;
      end
      if (w[5:3] !== e.sym_b) begin
        $error("second_symbol exp %0d got %0d", e.sym_b, w[5:3]); errors++;
      end
      if (w[29:6] !== e.dist_a) begin
        $error("first_distance exp %0d got %0d", e.dist_a, w[29:6]); errors++;
      end
      if (w[53:30] !== e.dist_b) begin
        $error("second_distance exp %0d got %0d", e.dist_b, w[53:30]); errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;

  decision_scoreboard sb;
  bit quiet_phase;
  bit hold_rx;
  int hold_cycles;

  alamouti_ml_psk8_detector_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [127:0] d, logic last);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(d, last);
  endtask

  task automatic send_random(logic last);
    logic [127:0] d;
    for (int i = 0; i < 8; i++) d[i*16 +: 16] = rand_sample();
    send_word(d, last);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [127:0] d;
    int ant;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    quiet_phase = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, extremes, all-ones and ties
    send_word('0, 1'b1);
    send_word({8{16'h8000}}, 1'b1);
    send_word({8{16'h7fff}}, 1'b1);
    send_word({8{16'hffff}}, 1'b0);
    send_word({8{16'h5555}}, 1'b0);
    send_word({8{16'haaaa}}, 1'b1);
    // clean channel, each 8-psk point sent as both symbols
    for (int p = 0; p < 8; p++) begin
      d = '0;
      d[15:0] = 16'd4096;
      d[47:32] = 16'd2048;
      d[79:64] = 16'(sb.psk_coord(p * 2) / 2);
      d[95:80] = 16'(sb.psk_coord(p * 2 + 12) / 2);
      d[111:96] = 16'(sb.psk_coord(((7 - p) * 2) % 16) / 2);
      d[127:112] = 16'(sb.psk_coord((7 - p) * 2 + 12) / 2);
      send_word(d, p[0]);
    end
    // saturation: many full-scale antennas in one pair
    for (int i = 0; i < 10; i++) send_word({8{16'h8000}} ^ {i, 96'h0}, i == 9);
    drain();

    // random pairs of 1 to 4 antennas, a few long ones
    for (int n = 0; n < 820; ) begin
      ant = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      if (n > 740) quiet_phase = 1'b1;
      for (int a = 0; a < ant; a++) begin
        send_random(a == ant - 1);
        n++;
      end
      if (n > 300 && n < 310) drain();
    end
    drain();
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("alamouti_ml_psk8_detector_core_tb: clean");
    else
      $display("alamouti_ml_psk8_detector_core_tb: errors");
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_tready = 1'b0;
    hold_rx = 1'b0;
    hold_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (!hold_rx && sb.pending.size() >= 1) begin
        // hold long enough that input stalls behind the output
        hold_rx = 1'b1;
        hold_cycles = 3000;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        hold_cycles = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  initial begin
    #20_000_000;
    $display("alamouti_ml_psk8_detector_core_tb: errors");
    $finish;
  end

endmodule
